/* design/assert_macros.svh */
// Assertion helpers for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is released.
`define PPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked at every rising edge, reset included.
`define PPS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/pps_pkg.sv */
package pps_pkg;

    localparam int PLANE_BYTES = 16384;
    localparam int PLANE_COUNT = 4;
    localparam int WORD_W      = PLANE_COUNT * 8;
    localparam int ADDR_W      = $clog2(PLANE_BYTES);

    localparam int X_W        = 12;
    localparam int Y_W        = 10;
    localparam int STRIDE_W   = 8;
    localparam int LIMIT_W    = 10;
    localparam int OFFSET_W   = 18;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 1;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 8'd40;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 10'd224;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LIMIT  = 1'b1;

    // Command codes.
    localparam logic CMD_PLOT    = 1'b0;
    localparam logic CMD_RESTORE = 1'b1;

    typedef struct packed {
        logic                   command;
        logic [X_W-1:0]         x_coord;
        logic [Y_W-1:0]         y_coord;
        logic [PLANE_COUNT-1:0] restore_mask;
    } t_in_item;

    typedef struct packed {
        logic [PLANE_COUNT-1:0] changed_mask;
        logic                   rejected;
    } t_out_item;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        logic                reject;
    } t_addr_info;

endpackage

/* design/pps_plane_ram.sv */
module pps_plane_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/pps_addr_gen.sv */
module pps_addr_gen (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [pps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pps_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_load,
    input  logic [pps_pkg::X_W-1:0]   i_x_coord,
    input  logic [pps_pkg::Y_W-1:0]   i_y_coord,
    output pps_pkg::t_addr_info       o_info
);

    import pps_pkg::*;

    logic [STRIDE_W-1:0] r_stride;
    logic [LIMIT_W-1:0]  r_limit;
    t_addr_info          r_info;
    t_addr_info          n_info;
    logic [OFFSET_W-1:0] product;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stride <= STRIDE_RESET;
            r_limit  <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LINE_STRIDE: r_stride <= i_cfg_data[STRIDE_W-1:0];
                CFG_LINE_LIMIT:  r_limit  <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Byte offset is stride * y plus the byte column; the widest case still fits.
    always_comb begin
        product       = OFFSET_W'(r_stride) * OFFSET_W'(i_y_coord);
        n_info.offset = product + OFFSET_W'(i_x_coord[X_W-1:3]);
        n_info.reject = (i_y_coord >= r_limit)
                     || (n_info.offset >= OFFSET_W'(PLANE_BYTES));
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_info <= n_info;
        end
    end

    assign o_info = r_info;

endmodule

/* design/planar_pixel_set_and_restore.sv */
// Four-bitplane pixel plot and restore engine. Each memory word holds the four
// plane bytes at one byte offset (stride * y + x / 8). After reset the block
// zeroes the plane memory, one word per cycle, and stalls the input channel
// while it does so; configuration writes are taken throughout. An item then
// passes through accept, address and read, and modify and write back, and a
// rejected item ends after the address step; the next item is taken only once
// it is through, set by the read-modify-write through the single plane memory.
// The result waits in an output register, so a stall on the output only holds
// the block once a second result is ready.
`include "assert_macros.svh"

module planar_pixel_set_and_restore (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pps_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pps_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pps_pkg::t_out_item            o_out_item
);

    import pps_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_MODIFY
    } t_state;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PLANE_BYTES - 1);

    t_state                 r_state;
    t_state                 n_state;
    logic [ADDR_W-1:0]      r_clr_addr;
    logic                   r_cmd;
    logic [PLANE_COUNT-1:0] r_mask;
    logic [2:0]             r_xlow;
    logic                   r_out_valid;
    t_out_item              r_out_item;

    logic                   in_xfer;
    logic                   out_free;
    t_addr_info             info;
    logic                   ram_we;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic [WORD_W-1:0]      ram_rdata;
    logic [WORD_W-1:0]      mod_word;
    logic [PLANE_COUNT-1:0] mod_mask;
    logic [2:0]             bit_idx;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    pps_addr_gen u_addr_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_load      (in_xfer),
        .i_x_coord   (i_in_item.x_coord),
        .i_y_coord   (i_in_item.y_coord),
        .o_info      (info)
    );

    // Bit 7 of each plane byte is the leftmost pixel.
    always_comb begin
        bit_idx  = 3'd7 - r_xlow;
        mod_word = ram_rdata;
        mod_mask = '0;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            if (r_cmd == CMD_PLOT) begin
                if (!ram_rdata[p*8 + int'(bit_idx)]) begin
                    mod_word[p*8 + int'(bit_idx)] = 1'b1;
                    mod_mask[p] = 1'b1;
                end
            end else begin
                if (r_mask[p]) begin
                    mod_word[p*8 + int'(bit_idx)] = 1'b0;
                    mod_mask[p] = 1'b1;
                end
            end
        end
    end

    // One item is in flight at a time, so a read never meets a pending write.
    always_comb begin
        ram_re    = (r_state == ST_LOOKUP) && !info.reject;
        ram_we    = 1'b0;
        ram_waddr = info.offset[ADDR_W-1:0];
        ram_wdata = mod_word;
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else if (r_state == ST_MODIFY && out_free) begin
            ram_we = 1'b1;
        end
    end

    pps_plane_ram #(
        .DEPTH (PLANE_BYTES),
        .WIDTH (WORD_W)
    ) u_plane_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (info.offset[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr_addr == LAST_ADDR) n_state = ST_IDLE;
            ST_IDLE:   if (in_xfer) n_state = ST_LOOKUP;
            ST_LOOKUP: begin
                if (!info.reject) begin
                    n_state = ST_MODIFY;
                end else if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MODIFY: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_LOOKUP && info.reject && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_state == ST_MODIFY && out_free) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd  <= i_in_item.command;
            r_mask <= i_in_item.restore_mask;
            r_xlow <= i_in_item.x_coord[2:0];
        end
        if (r_state == ST_LOOKUP && info.reject && out_free) begin
            r_out_item.changed_mask <= '0;
            r_out_item.rejected     <= 1'b1;
        end else if (r_state == ST_MODIFY && out_free) begin
            r_out_item.changed_mask <= mod_mask;
            r_out_item.rejected     <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `PPS_ASSERT_ALWAYS(a_no_read_during_write, i_clk, !i_rst_n || !(ram_we && ram_re), "plane memory read and write collide")
    `PPS_ASSERT(a_result_source, i_clk, i_rst_n, $rose(o_out_valid) |-> ($past(r_state) == ST_LOOKUP || $past(r_state) == ST_MODIFY), "result appeared outside lookup or modify")
    `PPS_ASSERT(a_reject_zero_mask, i_clk, i_rst_n, (o_out_valid && o_out_item.rejected) |-> (o_out_item.changed_mask == '0), "rejected result carries a nonzero mask")
    `PPS_ASSERT(a_clear_complete, i_clk, i_rst_n, ($past(r_state) == ST_CLEAR && r_state == ST_IDLE) |-> ($past(r_clr_addr) == LAST_ADDR), "clearing pass ended early")

endmodule
